// ----- sv/mel_pkg.sv -----
// Shared widths, control codes, control word layout and microprogram of the ellipse rasterizer.
package mel_pkg;

  localparam int RADIUS_BITS  = 10;
  localparam int COORD_BITS   = 12;
  localparam int OUT_BITS     = COORD_BITS + 1;
  localparam int XW           = RADIUS_BITS + 1;
  localparam int YW           = RADIUS_BITS + 2;
  localparam int SQ_BITS      = 2 * RADIUS_BITS;
  localparam int OP_BITS      = 2 * XW + 3;
  localparam int DEC_BITS     = 48;
  localparam int PC_BITS      = 6;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_BITS     = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_X = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_Y = CFG_IDX_BITS'(3);

  localparam logic [3:0] OP_ZERO = 4'd0;
  localparam logic [3:0] OP_RX   = 4'd1;
  localparam logic [3:0] OP_RY   = 4'd2;
  localparam logic [3:0] OP_RX2  = 4'd3;
  localparam logic [3:0] OP_RY2  = 4'd4;
  localparam logic [3:0] OP_X    = 4'd5;
  localparam logic [3:0] OP_Y    = 4'd6;
  localparam logic [3:0] OP_TX   = 4'd7;
  localparam logic [3:0] OP_DY   = 4'd8;
  localparam logic [3:0] OP_ONE  = 4'd9;
  localparam logic [3:0] OP_P    = 4'd10;

  localparam logic [3:0] ACC_NOP   = 4'd0;
  localparam logic [3:0] ACC_LOAD  = 4'd1;
  localparam logic [3:0] ACC_ADD   = 4'd2;
  localparam logic [3:0] ACC_ADD2  = 4'd3;
  localparam logic [3:0] ACC_ADD4  = 4'd4;
  localparam logic [3:0] ACC_SUB   = 4'd5;
  localparam logic [3:0] ACC_SUB2  = 4'd6;
  localparam logic [3:0] ACC_SUB4  = 4'd7;
  localparam logic [3:0] ACC_ADDQ  = 4'd8;
  localparam logic [3:0] ACC_QUART = 4'd9;

  localparam logic [2:0] WR_NONE = 3'b000;
  localparam logic [2:0] WR_RX2  = 3'b001;
  localparam logic [2:0] WR_RY2  = 3'b010;
  localparam logic [2:0] WR_TMP  = 3'b100;

  localparam logic [2:0] XY_NONE  = 3'd0;
  localparam logic [2:0] XY_XINC  = 3'd1;
  localparam logic [2:0] XY_YDEC  = 3'd2;
  localparam logic [2:0] XY_START = 3'd3;
  localparam logic [2:0] XY_SETR2 = 3'd4;

  localparam logic [2:0] C_NONE = 3'd0;
  localparam logic [2:0] C_FIN  = 3'd1;
  localparam logic [2:0] C_REG2 = 3'd2;
  localparam logic [2:0] C_LT   = 3'd3;
  localparam logic [2:0] C_NEG  = 3'd4;
  localparam logic [2:0] C_LE0  = 3'd5;

  localparam logic [PC_BITS-1:0] PC_RESTART = PC_BITS'(0);
  localparam logic [PC_BITS-1:0] PC_STEP    = PC_BITS'(5);
  localparam logic [PC_BITS-1:0] PC_EMIT    = PC_BITS'(18);
  localparam logic [PC_BITS-1:0] PC_R1NEG   = PC_BITS'(24);
  localparam logic [PC_BITS-1:0] PC_R2      = PC_BITS'(27);
  localparam logic [PC_BITS-1:0] PC_R2X     = PC_BITS'(31);
  localparam logic [PC_BITS-1:0] PC_STOP    = PC_BITS'(36);
  localparam logic [PC_BITS-1:0] PC_NONE    = PC_BITS'(0);

  typedef struct packed {
    logic [3:0]         a_sel;
    logic [3:0]         b_sel;
    logic [3:0]         acc_op;
    logic [2:0]         wr;
    logic [2:0]         xy_op;
    logic [2:0]         cond;
    logic [PC_BITS-1:0] target;
    logic               emit;
    logic               fin;
  } ctrl_t;

  typedef struct packed {
    logic fin;
    logic region;
    logic neg;
    logic le0;
    logic ge;
  } stat_t;

  function automatic ctrl_t mk(logic [3:0] a, logic [3:0] b, logic [3:0] op,
                               logic [2:0] wr, logic [2:0] xy, logic [2:0] cnd,
                               logic [PC_BITS-1:0] tgt, logic em, logic fn);
    ctrl_t w;
    w.a_sel  = a;
    w.b_sel  = b;
    w.acc_op = op;
    w.wr     = wr;
    w.xy_op  = xy;
    w.cond   = cnd;
    w.target = tgt;
    w.emit   = em;
    w.fin    = fn;
    return w;
  endfunction

  function automatic ctrl_t mel_rom(logic [PC_BITS-1:0] addr);
    ctrl_t w;
    case (addr)
      // restart: rx2, ry2, decision = ry2 - rx2*ry + rx2/4
      6'd0:  w = mk(OP_RX,   OP_RX,  ACC_NOP,   WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd1:  w = mk(OP_RY,   OP_RY,  ACC_NOP,   WR_RX2,  XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd2:  w = mk(OP_RX2,  OP_RY,  ACC_LOAD,  WR_RY2,  XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd3:  w = mk(OP_RX2,  OP_ONE, ACC_SUB,   WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd4:  w = mk(OP_ZERO, OP_ZERO, ACC_ADDQ, WR_NONE, XY_START, C_NONE, PC_NONE, 1'b0, 1'b1);
      // step: squares, finished test, region switch test
      6'd5:  w = mk(OP_RX,   OP_RX,  ACC_NOP,   WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd6:  w = mk(OP_RY,   OP_RY,  ACC_NOP,   WR_RX2,  XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd7:  w = mk(OP_ZERO, OP_ZERO, ACC_NOP,  WR_RY2,  XY_NONE,  C_FIN,  PC_STOP, 1'b0, 1'b0);
      6'd8:  w = mk(OP_X,    OP_RY2, ACC_NOP,   WR_NONE, XY_NONE,  C_REG2, PC_EMIT, 1'b0, 1'b0);
      6'd9:  w = mk(OP_Y,    OP_RX2, ACC_NOP,   WR_TMP,  XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd10: w = mk(OP_ZERO, OP_ZERO, ACC_NOP,  WR_NONE, XY_NONE,  C_LT,   PC_EMIT, 1'b0, 1'b0);
      // region two entry decision
      6'd11: w = mk(OP_TX,   OP_TX,  ACC_NOP,   WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd12: w = mk(OP_P,    OP_RY2, ACC_NOP,   WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd13: w = mk(OP_DY,   OP_DY,  ACC_LOAD,  WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd14: w = mk(OP_P,    OP_RX2, ACC_NOP,   WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd15: w = mk(OP_RX2,  OP_RY2, ACC_ADD4,  WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd16: w = mk(OP_ZERO, OP_ZERO, ACC_SUB4, WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd17: w = mk(OP_ZERO, OP_ZERO, ACC_QUART, WR_NONE, XY_SETR2, C_NONE, PC_NONE, 1'b0, 1'b0);
      // emit the beat
      6'd18: w = mk(OP_ZERO, OP_ZERO, ACC_NOP,  WR_NONE, XY_NONE,  C_REG2, PC_R2,   1'b1, 1'b0);
      // region one
      6'd19: w = mk(OP_ZERO, OP_ZERO, ACC_NOP,  WR_NONE, XY_XINC,  C_NEG,  PC_R1NEG, 1'b0, 1'b0);
      6'd20: w = mk(OP_X,    OP_RY2, ACC_NOP,   WR_NONE, XY_YDEC,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd21: w = mk(OP_RY2,  OP_ONE, ACC_ADD2,  WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd22: w = mk(OP_RX2,  OP_Y,   ACC_ADD,   WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd23: w = mk(OP_ZERO, OP_ZERO, ACC_SUB2, WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b1);
      6'd24: w = mk(OP_X,    OP_RY2, ACC_NOP,   WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd25: w = mk(OP_RY2,  OP_ONE, ACC_ADD2,  WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd26: w = mk(OP_ZERO, OP_ZERO, ACC_ADD,  WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b1);
      // region two
      6'd27: w = mk(OP_ZERO, OP_ZERO, ACC_NOP,  WR_NONE, XY_YDEC,  C_LE0,  PC_R2X,  1'b0, 1'b0);
      6'd28: w = mk(OP_RX2,  OP_Y,   ACC_NOP,   WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd29: w = mk(OP_RX2,  OP_ONE, ACC_SUB2,  WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd30: w = mk(OP_ZERO, OP_ZERO, ACC_ADD,  WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b1);
      6'd31: w = mk(OP_ZERO, OP_ZERO, ACC_NOP,  WR_NONE, XY_XINC,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd32: w = mk(OP_X,    OP_RY2, ACC_NOP,   WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd33: w = mk(OP_RX2,  OP_Y,   ACC_ADD2,  WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd34: w = mk(OP_RX2,  OP_ONE, ACC_SUB2,  WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b0);
      6'd35: w = mk(OP_ZERO, OP_ZERO, ACC_ADD,  WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b1);
      6'd36: w = mk(OP_ZERO, OP_ZERO, ACC_NOP,  WR_NONE, XY_NONE,  C_NONE, PC_NONE, 1'b0, 1'b1);
      default: w = mk(OP_ZERO, OP_ZERO, ACC_NOP, WR_NONE, XY_NONE, C_NONE, PC_NONE, 1'b0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// ----- sv/mel_datapath.sv -----
// Shared multiplier, decision accumulator and trace offsets driven by the control word.
module mel_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mel_pkg::ctrl_t                       cw,
  input  logic [mel_pkg::RADIUS_BITS-1:0]      radius_x,
  input  logic [mel_pkg::RADIUS_BITS-1:0]      radius_y,
  output logic [mel_pkg::XW-1:0]               offset_x,
  output logic signed [mel_pkg::YW-1:0]        offset_y,
  output logic                                 region,
  output mel_pkg::stat_t                       stat
);
  import mel_pkg::*;

  logic [SQ_BITS-1:0]             rx2;
  logic [SQ_BITS-1:0]             ry2;
  logic [DEC_BITS-1:0]            p;
  logic [DEC_BITS-1:0]            tmp;
  logic [DEC_BITS-1:0]            acc;
  logic [DEC_BITS-1:0]            acc_next;
  logic signed [YW:0]             dy;
  logic signed [OP_BITS-1:0]      a_op;
  logic signed [OP_BITS-1:0]      b_op;
  logic signed [2*OP_BITS-1:0]    prod;
  logic [DEC_BITS-1:0]            mag;
  logic [DEC_BITS-1:0]            quart;

  function automatic logic signed [OP_BITS-1:0] opnd(logic [3:0] sel);
    logic signed [OP_BITS-1:0] v;
    case (sel)
      OP_RX:   v = OP_BITS'(radius_x);
      OP_RY:   v = OP_BITS'(radius_y);
      OP_RX2:  v = OP_BITS'(rx2);
      OP_RY2:  v = OP_BITS'(ry2);
      OP_X:    v = OP_BITS'(offset_x);
      OP_Y:    v = OP_BITS'(offset_y);
      OP_TX:   v = OP_BITS'({offset_x, 1'b1});
      OP_DY:   v = OP_BITS'(dy);
      OP_ONE:  v = OP_BITS'(1);
      OP_P:    v = p[OP_BITS-1:0];
      default: v = '0;
    endcase
    return v;
  endfunction

  assign dy   = {offset_y[YW-1], offset_y} - 1'b1;

  always_comb begin
    a_op = opnd(cw.a_sel);
    b_op = opnd(cw.b_sel);
  end

  assign prod = a_op * b_op;

  assign mag   = acc[DEC_BITS-1] ? (~acc + 1'b1) : acc;
  assign quart = acc[DEC_BITS-1] ? (~(mag >> 2) + 1'b1) : (mag >> 2);

  always_comb begin
    case (cw.acc_op)
      ACC_LOAD:  acc_next = p;
      ACC_ADD:   acc_next = acc + p;
      ACC_ADD2:  acc_next = acc + (p << 1);
      ACC_ADD4:  acc_next = acc + (p << 2);
      ACC_SUB:   acc_next = acc - p;
      ACC_SUB2:  acc_next = acc - (p << 1);
      ACC_SUB4:  acc_next = acc - (p << 2);
      ACC_ADDQ:  acc_next = acc + (p >> 2);
      ACC_QUART: acc_next = quart;
      default:   acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    p <= prod[DEC_BITS-1:0];
    if (cw.wr[0]) rx2 <= p[SQ_BITS-1:0];
    if (cw.wr[1]) ry2 <= p[SQ_BITS-1:0];
    if (cw.wr[2]) tmp <= p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      offset_x <= '0;
      offset_y <= '1;
      region   <= 1'b0;
    end else begin
      acc <= acc_next;
      case (cw.xy_op)
        XY_XINC:  offset_x <= offset_x + 1'b1;
        XY_YDEC:  offset_y <= offset_y - 1'b1;
        XY_START: begin
          offset_x <= '0;
          offset_y <= {{(YW-RADIUS_BITS){1'b0}}, radius_y};
          region   <= 1'b0;
        end
        XY_SETR2: region <= 1'b1;
        default: ;
      endcase
    end
  end

  assign stat.fin    = offset_y[YW-1];
  assign stat.region = region;
  assign stat.neg    = acc[DEC_BITS-1];
  assign stat.le0    = acc[DEC_BITS-1] || (acc == '0);
  assign stat.ge     = $signed(tmp) >= $signed(p);

  a_region_holds: assert property (@(posedge clk) disable iff (rst)
    region && (cw.xy_op != XY_START) |=> region)
    else $error("region two dropped without a restart");

  a_setr2: assert property (@(posedge clk) disable iff (rst)
    (cw.xy_op == XY_SETR2) |=> region)
    else $error("region switch not taken");

endmodule

// ----- sv/midpoint_ellipse_generator.sv -----
// Top level: configuration registers, microcode sequencer and output register.
// A restart beat gives no result. A step beat gives one result in region one, in region
// two and at the region switch, and none once the trace is finished; the result is
// registered from the emit microstep, which holds while a pending result is stalled.
// The single shared multiplier gives one product per microstep.
// Synchronous reset clears the configuration to zero and marks the trace finished.
module midpoint_ellipse_generator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [mel_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [mel_pkg::CFG_BITS-1:0]           cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   restart,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mel_pkg::OUT_BITS-1:0]    px_right,
  output logic signed [mel_pkg::OUT_BITS-1:0]    px_left,
  output logic signed [mel_pkg::OUT_BITS-1:0]    py_low,
  output logic signed [mel_pkg::OUT_BITS-1:0]    py_high,
  output logic                                   in_region_two
);
  import mel_pkg::*;

  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] radius_x;
  logic [RADIUS_BITS-1:0] radius_y;
  logic                   busy;
  logic [PC_BITS-1:0]     pc;
  ctrl_t                  cw_rom;
  ctrl_t                  cw;
  stat_t                  stat;
  logic                   hold;
  logic                   take;
  logic [XW-1:0]          offset_x;
  logic signed [YW-1:0]   offset_y;
  logic                   region;
  logic [OUT_BITS-1:0]    cx_e;
  logic [OUT_BITS-1:0]    cy_e;
  logic [OUT_BITS-1:0]    x_e;
  logic [OUT_BITS-1:0]    y_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius_x <= '0;
      radius_y <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data[COORD_BITS-1:0];
        REG_CENTER_Y: center_y <= cfg_data[COORD_BITS-1:0];
        REG_RADIUS_X: radius_x <= cfg_data[RADIUS_BITS-1:0];
        REG_RADIUS_Y: radius_y <= cfg_data[RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cw_rom   = mel_rom(pc);
  assign hold     = cw_rom.emit && out_valid && out_stall;
  assign cw       = (busy && !hold) ? cw_rom : '0;
  assign in_stall = busy;

  always_comb begin
    case (cw.cond)
      C_FIN:   take = stat.fin;
      C_REG2:  take = stat.region;
      C_LT:    take = !stat.ge;
      C_NEG:   take = stat.neg;
      C_LE0:   take = stat.le0;
      default: take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PC_RESTART;
    end else if (!busy) begin
      if (in_valid) begin
        busy <= 1'b1;
        pc   <= restart ? PC_RESTART : PC_STEP;
      end
    end else if (!hold) begin
      if (cw.fin) busy <= 1'b0;
      pc <= take ? cw.target : pc + 1'b1;
    end
  end

  mel_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cw       (cw),
    .radius_x (radius_x),
    .radius_y (radius_y),
    .offset_x (offset_x),
    .offset_y (offset_y),
    .region   (region),
    .stat     (stat)
  );

  assign cx_e = {center_x[COORD_BITS-1], center_x};
  assign cy_e = {center_y[COORD_BITS-1], center_y};
  assign x_e  = {{(OUT_BITS-XW){1'b0}}, offset_x};
  assign y_e  = {{(OUT_BITS-YW){offset_y[YW-1]}}, offset_y};

  always_ff @(posedge clk) begin
    if (cw.emit) begin
      px_right      <= cx_e + x_e;
      px_left       <= cx_e - x_e;
      py_low        <= cy_e - y_e;
      py_high       <= cy_e + y_e;
      in_region_two <= region;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> busy)
    else $error("accepted beat did not start the sequencer");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && cw_rom.emit && out_valid && out_stall) |=> (busy && pc == $past(pc)))
    else $error("sequencer moved past emit with a pending result");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pc <= PC_STOP))
    else $error("step counter left the program");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy && cw_rom.emit))
    else $error("result raised without an emit step");

endmodule
